// File: sv/hcbd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// HTTP chunked body decoder package
// Shared types, character codes and helpers for the chunked body decoder.
// ----------------------------------------------------------------------------
package hcbd_pkg;

    localparam int unsigned LINE_LIMIT_DEF = 127;
    localparam logic [31:0] MAX_BODY_RESET = 32'd65536;
    localparam int unsigned SIZE_W         = 33;
    localparam logic [SIZE_W-1:0] SIZE_SAT = {SIZE_W{1'b1}};

    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_SP  = 8'h20;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_XLO = 8'h78;
    localparam logic [7:0] CH_XUP = 8'h58;

    typedef enum logic [2:0] {
        PH_BLANK    = 3'd0,
        PH_DIGITS   = 3'd1,
        PH_REST     = 3'd2,
        PH_NODIGIT  = 3'd3,
        PH_DATA     = 3'd4,
        PH_DATA_END = 3'd5,
        PH_TRAILER  = 3'd6,
        PH_IDLE     = 3'd7
    } phase_t;

    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_DONE  = 2'd1,
        KIND_ERROR = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ERR_LONG   = 2'd0,
        ERR_NOHEX  = 2'd1,
        ERR_BUDGET = 2'd2,
        ERR_CRLF   = 2'd3
    } err_t;

    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } hex_t;

    function automatic hex_t hex_decode(input logic [7:0] c);
        hex_t h;
        h.valid = 1'b1;
        h.value = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            h.value = 4'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            h.value = 4'(c - 8'h57);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            h.value = 4'(c - 8'h37);
        end else begin
            h.valid = 1'b0;
        end
        return h;
    endfunction

endpackage
`default_nettype wire

// File: sv/http_chunked_body_decoder_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// HTTP chunked body decoder
// Decodes an HTTP/1.1 chunked transfer-coded body one byte per transfer.
// ----------------------------------------------------------------------------
// The input stream carries one raw body byte per transfer in s_axis_tdata;
// s_axis_tuser set on a transfer clears the decoder so that byte begins a new
// body. Each input transfer yields zero or one result transfer on the output
// stream: a decoded data byte, a completion with the total length, or an
// error with its code. After completion or an error, bytes are dropped until
// the next transfer with s_axis_tuser set.
// The whole decode step sits between the decoder state and the result register,
// so a result shows in the cycle after its byte and the block takes one byte
// every cycle while the result register can take it. The result register holds
// one result; while it is full and the receiver holds m_axis_tready low,
// s_axis_tready is low too. The budget register is written through cfg_wr_en
// and cfg_wr_data; the user must write it only while the block is idle, which
// the block itself does not enforce. Reset loads a budget of 65536 bytes, empties
// the result register and starts a new body at its first size line; no clearing pass.
// ----------------------------------------------------------------------------
module http_chunked_body_decoder_unit
    import hcbd_pkg::*;
#(
    parameter int unsigned LINE_LIMIT = LINE_LIMIT_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [31:0] cfg_wr_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  wire logic        s_axis_tuser,   // [0] start_body
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [47:0]      m_axis_tdata,   // [7:0] data_byte, [9:8] error_code,
                                             // [41:10] total_len, rest zero
    output logic [1:0]       m_axis_tuser    // [1:0] result_kind
);

    localparam int unsigned LC_W = $clog2(LINE_LIMIT + 1);

    logic [31:0]       max_body_reg;
    phase_t            phase_reg, phase_next;
    logic [SIZE_W-1:0] size_reg, size_next;
    logic [31:0]       chunk_reg, chunk_next;
    logic [31:0]       total_reg, total_next;
    logic [LC_W-1:0]   lc_reg, lc_next;
    logic              pcr_reg, pcr_next;
    logic              empty_reg, empty_next;

    logic              out_valid_reg, out_valid_next;
    kind_t             out_kind_reg;
    logic [7:0]        out_data_reg;
    err_t              out_code_reg;
    logic [31:0]       out_len_reg;

    logic              s_accept;
    logic              m_accept;
    logic [7:0]        b;
    phase_t            cur_phase;
    logic [SIZE_W-1:0] cur_size;
    logic [31:0]       cur_chunk;
    logic [31:0]       cur_total;
    logic [LC_W-1:0]   cur_lc;
    logic              cur_pcr;
    logic              cur_empty;
    logic [LC_W-1:0]   lc_inc;
    logic [31:0]       room;
    hex_t              hx;
    logic              res_valid;
    kind_t             res_kind;
    logic [7:0]        res_data;
    err_t              res_code;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign m_accept      = out_valid_reg && m_axis_tready;
    assign b             = s_axis_tdata;

    always_comb
    begin
        cur_phase  = s_axis_tuser ? PH_BLANK : phase_reg;
        cur_size   = s_axis_tuser ? '0 : size_reg;
        cur_chunk  = s_axis_tuser ? '0 : chunk_reg;
        cur_total  = s_axis_tuser ? '0 : total_reg;
        cur_lc     = s_axis_tuser ? '0 : lc_reg;
        cur_pcr    = s_axis_tuser ? 1'b0 : pcr_reg;
        cur_empty  = s_axis_tuser ? 1'b1 : empty_reg;
        lc_inc     = cur_lc + 1'b1;
        room       = (cur_total >= max_body_reg) ? 32'd0 : max_body_reg - cur_total;
        hx         = hex_decode(b);

        phase_next = phase_reg;
        size_next  = size_reg;
        chunk_next = chunk_reg;
        total_next = total_reg;
        lc_next    = lc_reg;
        pcr_next   = pcr_reg;
        empty_next = empty_reg;
        res_valid  = 1'b0;
        res_kind   = KIND_DATA;
        res_data   = 8'd0;
        res_code   = ERR_LONG;

        if (s_accept)
        begin
            phase_next = cur_phase;
            size_next  = cur_size;
            chunk_next = cur_chunk;
            total_next = cur_total;
            lc_next    = cur_lc;
            pcr_next   = cur_pcr;
            empty_next = cur_empty;
            case (cur_phase)
                PH_IDLE:
                begin
                end
                PH_DATA:
                begin
                    total_next = cur_total + 32'd1;
                    chunk_next = cur_chunk - 32'd1;
                    if (cur_chunk == 32'd1)
                    begin
                        phase_next = PH_DATA_END;
                        pcr_next   = 1'b0;
                    end
                    res_valid = 1'b1;
                    res_kind  = KIND_DATA;
                    res_data  = b;
                end
                PH_DATA_END:
                begin
                    if ((!cur_pcr && b != CH_CR) || (cur_pcr && b != CH_LF))
                    begin
                        phase_next = PH_IDLE;
                        res_valid  = 1'b1;
                        res_kind   = KIND_ERROR;
                        res_code   = ERR_CRLF;
                    end
                    else if (!cur_pcr)
                    begin
                        pcr_next = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_BLANK;
                        size_next  = '0;
                        lc_next    = '0;
                        pcr_next   = 1'b0;
                        empty_next = 1'b1;
                    end
                end
                default:
                begin
                    lc_next = lc_inc;
                    if (cur_pcr && b == CH_LF)
                    begin
                        size_next  = '0;
                        lc_next    = '0;
                        pcr_next   = 1'b0;
                        empty_next = 1'b1;
                        case (cur_phase)
                            PH_DIGITS, PH_REST:
                            begin
                                if (cur_size > {1'b0, room})
                                begin
                                    phase_next = PH_IDLE;
                                    res_valid  = 1'b1;
                                    res_kind   = KIND_ERROR;
                                    res_code   = ERR_BUDGET;
                                end
                                else if (cur_size == '0)
                                begin
                                    phase_next = PH_TRAILER;
                                end
                                else
                                begin
                                    chunk_next = cur_size[31:0];
                                    phase_next = PH_DATA;
                                end
                            end
                            PH_TRAILER:
                            begin
                                if (cur_empty)
                                begin
                                    phase_next = PH_IDLE;
                                    res_valid  = 1'b1;
                                    res_kind   = KIND_DONE;
                                end
                                else
                                begin
                                    phase_next = PH_TRAILER;
                                end
                            end
                            default:
                            begin
                                phase_next = PH_IDLE;
                                res_valid  = 1'b1;
                                res_kind   = KIND_ERROR;
                                res_code   = ERR_NOHEX;
                            end
                        endcase
                    end
                    else if (lc_inc >= LC_W'(LINE_LIMIT))
                    begin
                        phase_next = PH_IDLE;
                        res_valid  = 1'b1;
                        res_kind   = KIND_ERROR;
                        res_code   = ERR_LONG;
                    end
                    else
                    begin
                        if (cur_phase == PH_BLANK)
                        begin
                            if (b inside {CH_SP, CH_TAB})
                            begin
                                phase_next = PH_BLANK;
                            end
                            else if (hx.valid)
                            begin
                                size_next  = SIZE_W'(hx.value);
                                phase_next = PH_DIGITS;
                            end
                            else
                            begin
                                phase_next = PH_NODIGIT;
                            end
                        end
                        else if (cur_phase == PH_DIGITS)
                        begin
                            if (hx.valid)
                            begin
                                if (cur_size[SIZE_W-1:SIZE_W-4] != 4'd0)
                                begin
                                    size_next = SIZE_SAT;
                                end
                                else
                                begin
                                    size_next = {cur_size[SIZE_W-5:0], hx.value};
                                end
                            end
                            else if ((b inside {CH_XLO, CH_XUP}) && cur_size == '0)
                            begin
                                phase_next = PH_NODIGIT;
                            end
                            else
                            begin
                                phase_next = PH_REST;
                            end
                        end
                        empty_next = (lc_inc == LC_W'(1)) && (b == CH_CR);
                        pcr_next   = (b == CH_CR);
                    end
                end
            endcase
        end

        if (s_accept && res_valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_accept)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_body_reg  <= MAX_BODY_RESET;
            phase_reg     <= PH_BLANK;
            size_reg      <= '0;
            chunk_reg     <= '0;
            total_reg     <= '0;
            lc_reg        <= '0;
            pcr_reg       <= 1'b0;
            empty_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                max_body_reg <= cfg_wr_data;
            end
            phase_reg     <= phase_next;
            size_reg      <= size_next;
            chunk_reg     <= chunk_next;
            total_reg     <= total_next;
            lc_reg        <= lc_next;
            pcr_reg       <= pcr_next;
            empty_reg     <= empty_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept && res_valid)
        begin
            out_kind_reg <= res_kind;
            out_data_reg <= res_data;
            out_code_reg <= res_code;
            out_len_reg  <= total_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tdata  = {6'd0, out_len_reg, out_code_reg, out_data_reg};

    // A chunk in progress always has bytes left to pass.
    a_chunk_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DATA |-> chunk_reg != 32'd0)
        else $error("data phase with no bytes remaining");

    // A line that stays open is always shorter than the limit.
    a_line_short: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_BLANK || phase_reg == PH_DIGITS || phase_reg == PH_REST ||
         phase_reg == PH_NODIGIT || phase_reg == PH_TRAILER)
        |-> lc_reg < LC_W'(LINE_LIMIT))
        else $error("open line reached the length limit");

    // A byte taken after completion or an error produces no result.
    a_idle_silent: assert property (@(posedge clk) disable iff (!rst_n)
        s_accept && phase_reg == PH_IDLE && !s_axis_tuser |=> !out_valid_reg)
        else $error("result produced while idle");

    // Only data results carry a byte, and only errors carry a code.
    a_fields_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_kind_reg == KIND_DATA || out_data_reg == 8'd0) &&
                          (out_kind_reg == KIND_ERROR || out_code_reg == ERR_LONG))
        else $error("result carries a stray field");

    // The decoded length never exceeds the budget in force.
    a_budget: assert property (@(posedge clk) disable iff (!rst_n)
        s_accept && phase_reg == PH_DATA && !s_axis_tuser
        |-> total_reg < max_body_reg || $past(cfg_wr_en))
        else $error("decoded length over budget");

endmodule
`default_nettype wire
